// ===== sv/crc32rs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32rs_pkg
// Constants and the byte fold shared by the reflected CRC-32 stream unit.
// ----------------------------------------------------------------------------
package crc32rs_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0] PolyReset = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0] CrcZero   = '0;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  // Eight LSB-first shift steps of one byte against the reflected polynomial.
  function automatic crc_t fold_byte(input byte_t seed, input crc_t poly);
    crc_t v;
    v = {{(CrcWidth-ByteWidth){1'b0}}, seed};
    for (int k = 0; k < ByteWidth; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ poly;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/crc32_reflected_stream_unit.sv =====
// A byte marked last goes through the input register, then the result register.
// One byte per cycle while in_stall is low; the eight shift-XOR steps sit between
// the input register and the accumulator/result register.
// Reset: clears the accumulator and both valid stages; polynomial returns to
// 0xEDB88320.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_reflected_stream_unit
// Running reflected CRC-32 over a byte stream, zero seed, no final XOR.
// ----------------------------------------------------------------------------
module crc32_reflected_stream_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      crc_value
);

  crc32rs_pkg::crc_t  polynomial;
  crc32rs_pkg::crc_t  crc_acc;
  crc32rs_pkg::crc_t  crc_next;
  crc32rs_pkg::byte_t s1_byte;
  logic               s1_last;
  logic               s1_valid;
  logic               out_free;
  logic               s1_advance;
  logic               in_take;

  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && (!s1_last || out_free);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  assign crc_next = {8'h00, crc_acc[31:8]}
                  ^ crc32rs_pkg::fold_byte(crc_acc[7:0] ^ s1_byte, polynomial);

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= crc32rs_pkg::PolyReset;
    end else if (cfg_wr_en) begin
      polynomial <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  // accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc   <= crc32rs_pkg::CrcZero;
      out_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        crc_acc <= s1_last ? crc32rs_pkg::CrcZero : crc_next;
      end
      if (s1_advance && s1_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_advance && s1_last) begin
      crc_value <= crc_next;
    end
  end

`ifndef SYNTH
  a_last_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_last) |=> out_valid)
    else $error("last beat did not produce a result");

  a_last_clears_acc: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_last) |=> (crc_acc == crc32rs_pkg::CrcZero))
    else $error("accumulator not cleared after last beat");

  a_acc_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(crc_acc))
    else $error("accumulator changed without a beat");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire
